>>> rtl/core/fns_pkg.sv
`timescale 1ns / 1ps
// Shared defaults and controller/datapath interface types for the five-number summary block.
package fns_pkg;

	localparam int MAX_COUNT_DEF  = 1024;
	localparam int VALUE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 16;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // input item accepted
		logic pivot;      // read the pivot entry, clear rank counters
		logic scan;       // read one compare entry
		logic rank_next;  // capture order statistics, advance pivot
		logic mul_set_a;  // start n * sum of squares
		logic mul_step;   // one shift-add step
		logic mul_set_b;  // keep first product, start sum * sum
		logic sqrt_set;   // load radicand
		logic sqrt_step;  // one root bit
		logic div_set_s;  // start root / n
		logic div_step;   // one quotient bit
		logic div_set_m;  // keep stddev, start sum / n
		logic out_load;   // keep mean, result ready
		logic clear;      // result taken, start a new set
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic j_last;
		logic i_last;
		logic iter_last;
	} dp_sts_t;

endpackage

>>> rtl/core/fns_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module fns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/core/fns_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: load, rank scan, arithmetic phases and result handshake.
module fns_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             is_last,
	input  logic             out_stall,
	output logic             in_stall,
	output logic             out_valid,
	output fns_pkg::dp_cmd_t cmd,
	input  fns_pkg::dp_sts_t sts
);
	import fns_pkg::*;

	typedef enum logic [10:0] {
		S_LOAD  = 11'b00000000001,
		S_PIVOT = 11'b00000000010,
		S_SCAN  = 11'b00000000100,
		S_DRAIN = 11'b00000001000,
		S_NEXT  = 11'b00000010000,
		S_MUL1  = 11'b00000100000,
		S_MUL2  = 11'b00001000000,
		S_SQRT  = 11'b00010000000,
		S_DIVS  = 11'b00100000000,
		S_DIVM  = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = (state_q != S_LOAD);
	assign out_valid = (state_q == S_OUT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (is_last) begin
						state_d = S_PIVOT;
					end
				end
			end
			S_PIVOT: begin
				cmd.pivot = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.j_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_NEXT;
			end
			S_NEXT: begin
				cmd.rank_next = 1'b1;
				if (sts.i_last) begin
					cmd.mul_set_a = 1'b1;
					state_d       = S_MUL1;
				end else begin
					state_d = S_PIVOT;
				end
			end
			S_MUL1: begin
				cmd.mul_step = 1'b1;
				if (sts.iter_last) begin
					cmd.mul_set_b = 1'b1;
					state_d       = S_MUL2;
				end
			end
			S_MUL2: begin
				cmd.mul_step = 1'b1;
				if (sts.iter_last) begin
					cmd.sqrt_set = 1'b1;
					state_d      = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.iter_last) begin
					cmd.div_set_s = 1'b1;
					state_d       = S_DIVS;
				end
			end
			S_DIVS: begin
				cmd.div_step = 1'b1;
				if (sts.iter_last) begin
					cmd.div_set_m = 1'b1;
					state_d       = S_DIVM;
				end
			end
			S_DIVM: begin
				cmd.div_step = 1'b1;
				if (sts.iter_last) begin
					cmd.out_load = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_stall) begin
					cmd.clear = 1'b1;
					state_d   = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/fns_dp.sv
`timescale 1ns / 1ps
// Datapath: sample store, accumulators, rank scan, shift-add multiplier, root and divider.
module fns_dp #(
	parameter int MAX_COUNT  = fns_pkg::MAX_COUNT_DEF,
	parameter int VALUE_BITS = fns_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = fns_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fns_pkg::dp_cmd_t                   cmd,
	output fns_pkg::dp_sts_t                   sts,
	input  logic [VALUE_BITS-1:0]              sample_value,
	output logic [VALUE_BITS-1:0]              minimum,
	output logic [VALUE_BITS:0]                lower_quartile_x2,
	output logic [VALUE_BITS:0]                median_x2,
	output logic [VALUE_BITS:0]                upper_quartile_x2,
	output logic [VALUE_BITS-1:0]              maximum,
	output logic [VALUE_BITS+FRAC_BITS-1:0]    mean_fixed,
	output logic [VALUE_BITS+FRAC_BITS-1:0]    stddev_fixed,
	output logic [$clog2(MAX_COUNT+1)-1:0]     sample_count,
	output logic                               overflowed
);
	import fns_pkg::*;

	localparam int CNT_W  = $clog2(MAX_COUNT + 1);
	localparam int AW     = $clog2(MAX_COUNT);
	localparam int SQV_W  = 2 * VALUE_BITS;
	localparam int SUM_W  = VALUE_BITS + CNT_W;
	localparam int SQ_W   = 2 * VALUE_BITS + CNT_W;
	localparam int D_W    = 2 * SUM_W;
	localparam int ROOT_W = SUM_W + FRAC_BITS;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int DIV_W  = ROOT_W;
	localparam int OUT_W  = VALUE_BITS + FRAC_BITS;
	localparam int IT_W   = $clog2(DIV_W);
	localparam int NTGT   = 6;

	// set accumulators
	logic [CNT_W-1:0]      n_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]       sumsq_q;
	logic                  drop_q;
	logic [VALUE_BITS-1:0] min_q, max_q;
	logic [SQV_W-1:0]      sq_s1;
	logic                  sq_vld_s1;
	logic                  full, keep;

	// store
	logic [AW-1:0]         ram_addr;
	logic [VALUE_BITS-1:0] ram_rdata;

	// rank scan
	logic [AW-1:0]         i_q, j_q;
	logic                  pivot_vld_s1, cmp_vld_s1;
	logic [VALUE_BITS-1:0] pivot_q;
	logic [CNT_W-1:0]      lt_q, le_q;
	logic [CNT_W-1:0]      tgt [NTGT];
	logic [VALUE_BITS-1:0] tval_q [NTGT];
	logic [CNT_W-1:0]      half, qtr, m1, l1, u_off;

	// multiplier
	logic [D_W-1:0]        mul_a_q, mul_acc_q, acc_next, d_q;
	logic [SUM_W-1:0]      mul_b_q;

	// square root
	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_W-1:0]     root_q, root_next;
	logic [ROOT_W:0]       srem_q, srem_next;
	logic [ROOT_W+2:0]     s_r2, s_trial, s_diff;
	logic                  s_ge;

	// divider
	logic [DIV_W-1:0]      dvd_q, quot_next;
	logic [CNT_W-1:0]      drem_q, drem_next;
	logic [CNT_W:0]        d_t, d_sub;
	logic                  d_ge;

	logic [IT_W-1:0]       iter_q;
	logic [OUT_W-1:0]      mean_q, sd_q;

	assign full = (n_q == CNT_W'(MAX_COUNT));
	assign keep = cmd.load && !full;

	// store address: write slot while loading, pivot or compare entry otherwise
	always_comb begin
		if (keep) begin
			ram_addr = n_q[AW-1:0];
		end else if (cmd.pivot) begin
			ram_addr = i_q;
		end else begin
			ram_addr = j_q;
		end
	end

	fns_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(MAX_COUNT)
	) u_store (
		.clk  (clk),
		.we   (keep),
		.addr (ram_addr),
		.wdata(sample_value),
		.rdata(ram_rdata)
	);

	// sorted positions wanted: median pair, lower pair, upper pair
	always_comb begin
		half  = n_q >> 1;
		qtr   = half >> 1;
		m1    = n_q[0] ? half : half - CNT_W'(1);
		l1    = half[0] ? qtr : qtr - CNT_W'(1);
		u_off = half + CNT_W'(n_q[0]);
		if (n_q == CNT_W'(1)) begin
			for (int k = 0; k < NTGT; k++) begin
				tgt[k] = m1;
			end
		end else begin
			tgt[0] = m1;
			tgt[1] = half;
			tgt[2] = l1;
			tgt[3] = qtr;
			tgt[4] = l1 + u_off;
			tgt[5] = qtr + u_off;
		end
	end

	// shift-add step
	assign acc_next = mul_b_q[0] ? mul_acc_q + mul_a_q : mul_acc_q;

	// root step: two radicand bits in, one root bit out
	assign s_r2      = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign s_trial   = {1'b0, root_q, 2'b01};
	assign s_diff    = s_r2 - s_trial;
	assign s_ge      = (s_r2 >= s_trial);
	assign srem_next = s_ge ? s_diff[ROOT_W:0] : s_r2[ROOT_W:0];
	assign root_next = {root_q[ROOT_W-2:0], s_ge};

	// restoring divide step by the count
	assign d_t       = {drem_q, dvd_q[DIV_W-1]};
	assign d_ge      = (d_t >= {1'b0, n_q});
	assign d_sub     = d_t - {1'b0, n_q};
	assign drem_next = d_ge ? d_sub[CNT_W-1:0] : d_t[CNT_W-1:0];
	assign quot_next = {dvd_q[DIV_W-2:0], d_ge};

	// loading and accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			sum_q     <= '0;
			sumsq_q   <= '0;
			drop_q    <= 1'b0;
			min_q     <= '1;
			max_q     <= '0;
			sq_vld_s1 <= 1'b0;
		end else begin
			sq_vld_s1 <= keep;
			if (sq_vld_s1) begin
				sumsq_q <= sumsq_q + SQ_W'(sq_s1);
			end
			if (cmd.clear) begin
				n_q     <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
				drop_q  <= 1'b0;
				min_q   <= '1;
				max_q   <= '0;
			end else if (cmd.load) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					n_q   <= n_q + CNT_W'(1);
					sum_q <= sum_q + SUM_W'(sample_value);
					if (sample_value < min_q) begin
						min_q <= sample_value;
					end
					if (sample_value > max_q) begin
						max_q <= sample_value;
					end
				end
			end
		end
	end

	// square of the incoming value, added in the following cycle
	always_ff @(posedge clk) begin
		sq_s1 <= SQV_W'(sample_value) * SQV_W'(sample_value);
	end

	// rank scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q          <= '0;
			j_q          <= '0;
			lt_q         <= '0;
			le_q         <= '0;
			pivot_vld_s1 <= 1'b0;
			cmp_vld_s1   <= 1'b0;
		end else begin
			pivot_vld_s1 <= cmd.pivot;
			cmp_vld_s1   <= cmd.scan;
			if (cmd.clear) begin
				i_q <= '0;
			end else if (cmd.rank_next) begin
				i_q <= i_q + AW'(1);
			end
			if (cmd.pivot) begin
				j_q  <= '0;
				lt_q <= '0;
				le_q <= '0;
			end else begin
				if (cmd.scan) begin
					j_q <= j_q + AW'(1);
				end
				if (cmp_vld_s1) begin
					lt_q <= lt_q + CNT_W'(ram_rdata < pivot_q);
					le_q <= le_q + CNT_W'(ram_rdata <= pivot_q);
				end
			end
		end
	end

	// pivot value and order statistic capture
	always_ff @(posedge clk) begin
		if (pivot_vld_s1) begin
			pivot_q <= ram_rdata;
		end
		if (cmd.rank_next) begin
			for (int k = 0; k < NTGT; k++) begin
				if (lt_q <= tgt[k] && tgt[k] < le_q) begin
					tval_q[k] <= pivot_q;
				end
			end
		end
	end

	// iteration counter shared by all arithmetic phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.mul_set_a || cmd.mul_set_b) begin
			iter_q <= IT_W'(SUM_W - 1);
		end else if (cmd.sqrt_set) begin
			iter_q <= IT_W'(ROOT_W - 1);
		end else if (cmd.div_set_s || cmd.div_set_m) begin
			iter_q <= IT_W'(DIV_W - 1);
		end else if (cmd.mul_step || cmd.sqrt_step || cmd.div_step) begin
			iter_q <= iter_q - IT_W'(1);
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		// multiplier
		if (cmd.mul_set_a) begin
			mul_a_q   <= D_W'(sumsq_q);
			mul_b_q   <= SUM_W'(n_q);
			mul_acc_q <= '0;
		end else if (cmd.mul_set_b) begin
			d_q       <= acc_next;
			mul_a_q   <= D_W'(sum_q);
			mul_b_q   <= sum_q;
			mul_acc_q <= '0;
		end else if (cmd.mul_step) begin
			mul_acc_q <= acc_next;
			mul_a_q   <= mul_a_q << 1;
			mul_b_q   <= mul_b_q >> 1;
		end
		// square root of (n*sumsq - sum^2) scaled by 2^(2*FRAC_BITS)
		if (cmd.sqrt_set) begin
			rad_q  <= RAD_W'(d_q - acc_next) << (2 * FRAC_BITS);
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= rad_q << 2;
			root_q <= root_next;
			srem_q <= srem_next;
		end
		// divider: root / n first, then (sum << FRAC_BITS) / n
		if (cmd.div_set_s) begin
			dvd_q  <= root_next;
			drem_q <= '0;
		end else if (cmd.div_set_m) begin
			sd_q   <= quot_next[OUT_W-1:0];
			dvd_q  <= DIV_W'(sum_q) << FRAC_BITS;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= quot_next;
			drem_q <= drem_next;
		end
		if (cmd.out_load) begin
			mean_q <= quot_next[OUT_W-1:0];
		end
	end

	assign sts.j_last    = (CNT_W'(j_q) == n_q - CNT_W'(1));
	assign sts.i_last    = (CNT_W'(i_q) == n_q - CNT_W'(1));
	assign sts.iter_last = (iter_q == '0);

	// result fields
	assign minimum           = min_q;
	assign maximum           = max_q;
	assign median_x2         = {1'b0, tval_q[0]} + {1'b0, tval_q[1]};
	assign lower_quartile_x2 = {1'b0, tval_q[2]} + {1'b0, tval_q[3]};
	assign upper_quartile_x2 = {1'b0, tval_q[4]} + {1'b0, tval_q[5]};
	assign mean_fixed        = mean_q;
	assign stddev_fixed      = sd_q;
	assign sample_count      = n_q;
	assign overflowed        = drop_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_COUNT))
		else $error("kept count beyond capacity");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> CNT_W'(j_q) < n_q)
		else $error("compare index past kept count");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q != '0) |-> min_q <= max_q)
		else $error("minimum above maximum");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> drem_q < n_q)
		else $error("divider remainder not below count");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_step |-> srem_q <= {root_q, 1'b0})
		else $error("root remainder out of range");

endmodule

>>> rtl/core/five_number_summary_stats.sv
`timescale 1ns / 1ps
// Top level of the five-number summary, mean and standard deviation block.
//
// Input channel (in_valid / in_stall): one sample_value per item, one item per
// cycle while loading. The item with is_last set closes the set; it is kept too.
// Items past MAX_COUNT are dropped and reported through overflowed.
// After the closing item in_stall stays high until the result has been taken.
// Output channel (out_valid / out_stall): one result item per set, held stable
// while out_stall is high; the next set may start the cycle after it is taken.
// The rank scan compares each stored value against every stored value, itself
// included, through the single read port of the sample store. The remaining
// work is a bit-serial multiplier, a one-bit-per-cycle square root and a
// restoring divider.
// Reset clears the count, sums and overflow flag; store contents are not cleared
// and need no clearing pass, only values written in the current set are read.
module five_number_summary_stats #(
	parameter int MAX_COUNT  = fns_pkg::MAX_COUNT_DEF,
	parameter int VALUE_BITS = fns_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = fns_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [VALUE_BITS-1:0]           sample_value,
	input  logic                            is_last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [VALUE_BITS-1:0]           minimum,
	output logic [VALUE_BITS:0]             lower_quartile_x2,
	output logic [VALUE_BITS:0]             median_x2,
	output logic [VALUE_BITS:0]             upper_quartile_x2,
	output logic [VALUE_BITS-1:0]           maximum,
	output logic [VALUE_BITS+FRAC_BITS-1:0] mean_fixed,
	output logic [VALUE_BITS+FRAC_BITS-1:0] stddev_fixed,
	output logic [$clog2(MAX_COUNT+1)-1:0]  sample_count,
	output logic                            overflowed
);
	import fns_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer
	fns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_last  (is_last),
		.out_stall(out_stall),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath
	fns_dp #(
		.MAX_COUNT (MAX_COUNT),
		.VALUE_BITS(VALUE_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.sample_value     (sample_value),
		.minimum          (minimum),
		.lower_quartile_x2(lower_quartile_x2),
		.median_x2        (median_x2),
		.upper_quartile_x2(upper_quartile_x2),
		.maximum          (maximum),
		.mean_fixed       (mean_fixed),
		.stddev_fixed     (stddev_fixed),
		.sample_count     (sample_count),
		.overflowed       (overflowed)
	);

endmodule

>>> verif/five_number_summary_stats_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the five-number summary, mean and stddev block.
module five_number_summary_stats_tb;

	localparam int VB = fns_pkg::VALUE_BITS_DEF;
	localparam int FB = fns_pkg::FRAC_BITS_DEF;
	localparam int CAP = fns_pkg::MAX_COUNT_DEF;
	localparam int CB = $clog2(CAP + 1);
	localparam int WATCHDOG_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [VB-1:0] VMAX = {VB{1'b1}};

	typedef struct {
		logic [VB-1:0]    minimum;
		logic [VB:0]      lq;
		logic [VB:0]      med;
		logic [VB:0]      uq;
		logic [VB-1:0]    maximum;
		logic [VB+FB-1:0] mean;
		logic [VB+FB-1:0] sdev;
		logic [CB-1:0]    count;
		logic             ovf;
	} summary_t;

	typedef struct {
		logic [VB-1:0] value;
		logic          last;
		bit            has_exp;
		summary_t      exp;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [VB-1:0] sample_value = '0;
	logic is_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [VB-1:0] minimum;
	logic [VB:0] lower_quartile_x2, median_x2, upper_quartile_x2;
	logic [VB-1:0] maximum;
	logic [VB+FB-1:0] mean_fixed, stddev_fixed;
	logic [CB-1:0] sample_count;
	logic overflowed;

	five_number_summary_stats u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_value(sample_value), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.minimum(minimum), .lower_quartile_x2(lower_quartile_x2),
		.median_x2(median_x2), .upper_quartile_x2(upper_quartile_x2),
		.maximum(maximum), .mean_fixed(mean_fixed), .stddev_fixed(stddev_fixed),
		.sample_count(sample_count), .overflowed(overflowed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sample_t stim[$];
	summary_t pending_summaries[$];
	logic [VB-1:0] kept_values[$];
	bit set_dropped = 0;
	int offer_idx = 0;
	int accept_idx = 0;
	int error_count = 0;
	int result_count = 0;
	longint cycle_count = 0;
	int idle_cnt = 0;
	int hold_cnt = 0;
	bit hold_done = 0;

	// summary of the current set, computed from the kept values
	function automatic summary_t summarize(logic [VB-1:0] vals[$], bit dropped);
		summary_t s;
		logic [VB-1:0] srt[$];
		logic [127:0] total, sq_total, target, cand, prod;
		logic [127:0] acc;
		int n, h, odd, m1, m2, l1, l2;
		srt = vals;
		srt.sort();
		n = srt.size();
		total = 0;
		sq_total = 0;
		foreach (srt[i]) begin
			total += srt[i];
			sq_total += 128'(srt[i]) * srt[i];
		end
		m1 = (n % 2 == 0) ? n / 2 - 1 : n / 2;
		m2 = n / 2;
		s.med = srt[m1] + srt[m2];
		if (n == 1) begin
			s.lq = s.med;
			s.uq = s.med;
		end else begin
			h = n / 2;
			odd = n % 2;
			l1 = (h % 2 == 0) ? h / 2 - 1 : h / 2;
			l2 = h / 2;
			s.lq = srt[l1] + srt[l2];
			s.uq = srt[l1 + h + odd] + srt[l2 + h + odd];
		end
		s.minimum = srt[0];
		s.maximum = srt[n - 1];
		s.mean = (VB + FB)'((total << FB) / n);
		// largest r with (r*n)^2 <= (n*sumsq - sum^2) * 4^FB
		target = (sq_total * n - total * total) << (2 * FB);
		acc = 0;
		for (int b = VB + FB - 1; b >= 0; b--) begin
			cand = acc | (128'(1) << b);
			prod = cand * n;
			if (prod * prod <= target)
				acc = cand;
		end
		s.sdev = (VB + FB)'(acc);
		s.count = CB'(n);
		s.ovf = dropped;
		return s;
	endfunction

	function automatic summary_t mk_summary(logic [VB-1:0] mn, logic [VB:0] lq, logic [VB:0] md,
			logic [VB:0] uq, logic [VB-1:0] mx, logic [VB+FB-1:0] mean,
			logic [VB+FB-1:0] sdev, int n);
		summary_t s;
		s.minimum = mn; s.lq = lq; s.med = md; s.uq = uq; s.maximum = mx;
		s.mean = mean; s.sdev = sdev; s.count = CB'(n); s.ovf = 1'b0;
		return s;
	endfunction

	task automatic add_sample(logic [VB-1:0] v, logic last);
		sample_t t;
		t.value = v;
		t.last = last;
		t.has_exp = 0;
		stim.push_back(t);
	endtask

	task automatic add_checked(logic [VB-1:0] v, summary_t e);
		sample_t t;
		t.value = v;
		t.last = 1'b1;
		t.has_exp = 1;
		t.exp = e;
		stim.push_back(t);
	endtask

	// one random set; value style picks full range, narrow range (ties) or constant
	task automatic add_random_set(int len);
		int style;
		logic [VB-1:0] base;
		style = $urandom_range(0, 3);
		base = VB'($urandom);
		for (int i = 0; i < len; i++) begin
			case (style)
				0, 1: add_sample(VB'($urandom), i == len - 1);
				2: add_sample(VB'($urandom_range(0, 7)), i == len - 1);
				default: add_sample(base, i == len - 1);
			endcase
		end
	endtask

	// directed rows followed by random sets
	initial begin
		logic [VB-1:0] odd_vals[5];
		bit cap_done;
		cap_done = 0;
		add_checked('0, mk_summary('0, '0, '0, '0, '0, '0, '0, 1));
		add_checked(VMAX, mk_summary(VMAX, {VMAX, 1'b0}, {VMAX, 1'b0}, {VMAX, 1'b0},
			VMAX, {VMAX, {FB{1'b0}}}, '0, 1));
		// two extremes: mean and stddev both equal half of full scale
		add_sample('0, 1'b0);
		add_checked(VMAX, mk_summary('0, '0, (VB+1)'(VMAX), {VMAX, 1'b0}, VMAX,
			{1'b0, VMAX, {(FB-1){1'b0}}}, {1'b0, VMAX, {(FB-1){1'b0}}}, 2));
		odd_vals = '{24'hAAAAAA, 24'h555555, 24'h000001, 24'h800000, 24'hFFFFFE};
		for (int len = 3; len <= 6; len++)
			for (int i = 0; i < len; i++)
				add_sample(odd_vals[(i + len) % 5] ^ VB'(i), i == len - 1);
		// random part: mostly short sets, a few long ones, one past capacity
		while (stim.size() < 1700) begin
			if (!cap_done && stim.size() > 300) begin
				add_random_set(CAP + 6);
				cap_done = 1;
			end else if ($urandom_range(0, 19) == 0)
				add_random_set($urandom_range(40, 150));
			else
				add_random_set($urandom_range(1, 24));
		end
	end

	// sender: offer items, predict on each accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (kept_values.size() < CAP)
					kept_values.push_back(sample_value);
				else
					set_dropped = 1;
				if (is_last) begin
					if (stim[accept_idx].has_exp)
						pending_summaries.push_back(stim[accept_idx].exp);
					else
						pending_summaries.push_back(summarize(kept_values, set_dropped));
					kept_values.delete();
					set_dropped = 0;
				end
				accept_idx++;
			end
			if (!(in_valid && in_stall)) begin
				if (offer_idx < stim.size() &&
						((offer_idx > 600 && offer_idx < 900) || $urandom_range(0, 99) >= 22)) begin
					in_valid <= 1'b1;
					sample_value <= stim[offer_idx].value;
					is_last <= stim[offer_idx].last;
					offer_idx++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall, one long hold-off, quiet window
	always @(posedge clk) begin
		if (!hold_done && accept_idx > 150 && pending_summaries.size() > 0) begin
			hold_done <= 1;
			hold_cnt <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else if (accept_idx > 1500) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 22);
		end
	end

	task automatic report(string name, logic [127:0] exp_v, logic [127:0] got_v);
		error_count++;
		if (error_count <= 10)
			$display("mismatch result %0d %s: expected %0h got %0h",
				result_count, name, exp_v, got_v);
	endtask

	// compare each taken result with the oldest pending summary
	always @(posedge clk) begin
		summary_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_summaries.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("result %0d with nothing pending", result_count);
			end else begin
				e = pending_summaries.pop_front();
				if (minimum !== e.minimum) report("minimum", e.minimum, minimum);
				if (lower_quartile_x2 !== e.lq) report("lower_quartile_x2", e.lq, lower_quartile_x2);
				if (median_x2 !== e.med) report("median_x2", e.med, median_x2);
				if (upper_quartile_x2 !== e.uq) report("upper_quartile_x2", e.uq, upper_quartile_x2);
				if (maximum !== e.maximum) report("maximum", e.maximum, maximum);
				if (mean_fixed !== e.mean) report("mean_fixed", e.mean, mean_fixed);
				if (stddev_fixed !== e.sdev) report("stddev_fixed", e.sdev, stddev_fixed);
				if (sample_count !== e.count) report("sample_count", e.count, sample_count);
				if (overflowed !== e.ovf) report("overflowed", e.ovf, overflowed);
			end
			result_count++;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// reset, then wait for the stimulus to drain
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim.size() > 0);
		@(posedge clk);
		while (offer_idx < stim.size() || in_valid || pending_summaries.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
